// ===== hw/rtl/iptp_pkg.sv =====
// Shared types, codes and character helpers for the IP address text parser.
`default_nettype none

package iptp_pkg;

  localparam logic [3:0] FAM_V4 = 4'd2;
  localparam logic [3:0] FAM_V6 = 4'd10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam int unsigned NumGroups = 8;
  localparam int unsigned NumOctets = 3;
  localparam int unsigned MaxHexDigits = 4;
  localparam logic [11:0] OctetMax = 12'd255;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_NOFAM = 2'd2
  } status_e;

  // colon tracking between IPv6 groups
  typedef enum logic [1:0] {
    CP_NONE   = 2'd0,
    CP_SINGLE = 2'd1,
    CP_GAP    = 2'd2,
    CP_LEAD   = 2'd3
  } colon_phase_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t dec_digit(input logic [7:0] c);
    digit_t r;
    r.ok    = (c >= CH_ZERO) && (c <= CH_NINE);
    r.value = 4'(c - CH_ZERO);
    return r;
  endfunction

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t r;
    r.ok    = 1'b0;
    r.value = '0;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CH_ZERO);
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CH_LA + 8'd10);
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CH_UA + 8'd10);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/iptp_if.sv =====
// Valid/ready channel interfaces for address characters and parse results.
`default_nettype none

interface iptp_char_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [7:0] text_char;

  modport source (output valid, output opcode, output text_char, input ready);
  modport sink   (input valid, input opcode, input text_char, output ready);
endinterface

interface iptp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (output valid, output status, output addr_high, output addr_low, input ready);
  modport sink   (input valid, input status, input addr_high, input addr_low, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ip_address_text_parser.sv =====
// Result: registered on the transaction carrying the terminating zero; it appears in the next cycle.
// Throughput: one character per cycle; the input stalls only while a result waits unread.
// Each character updates the parse registers directly; the IPv6 gap expansion is a fixed
// mux in front of the result register.
// Reset: asynchronous, active low; clears parse state, marks the next character as a
// string start and empties the result register.
`default_nettype none

module ip_address_text_parser (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  iptp_char_if.sink   in_i,
  iptp_result_if.source out_o
);
  import iptp_pkg::*;

  logic [3:0]   fam_q, fam_d, fam_cur;
  logic         start_q, start_d;
  logic         err_q, err_d;
  logic [7:0]   oct_val_q, oct_val_d;
  logic         dig_q, dig_d;
  logic [1:0]   oct_cnt_q, oct_cnt_d;
  logic [7:0]   octs_q [NumOctets];
  logic         oct_we;
  logic [15:0]  grp_q [NumGroups];
  logic         grp_we;
  logic [3:0]   gcnt_q, gcnt_d;
  logic [3:0]   gpos_q, gpos_d;
  logic         gap_q, gap_d;
  logic [15:0]  gval_q, gval_d;
  logic [2:0]   hcnt_q, hcnt_d;
  colon_phase_e cph_q, cph_d;

  logic         out_valid_q, out_valid_d;
  status_e      status_q, status_d;
  logic [63:0]  hi_q, hi_d, lo_q, lo_d;

  logic         in_fire, is_term;
  digit_t       dec, hex;
  logic [11:0]  v4_sum;

  // finish path
  logic         fin_commit, fin_err, cnt_bad;
  logic [3:0]   gcnt_f, shift;
  logic [15:0]  grp_f [NumGroups];
  logic [15:0]  words [NumGroups];
  logic [3:0]   slot;

  assign in_i.ready      = !out_valid_q || out_o.ready;
  assign in_fire         = in_i.valid && in_i.ready;
  assign is_term         = (in_i.text_char == CH_NUL);
  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.addr_high = hi_q;
  assign out_o.addr_low  = lo_q;

  assign fam_cur = start_q ? in_i.opcode : fam_q;
  assign dec     = dec_digit(in_i.text_char);
  assign hex     = hex_digit(in_i.text_char);
  assign v4_sum  = 12'({oct_val_q, 3'b000}) + 12'({oct_val_q, 1'b0}) + 12'(dec.value);

  // Build the final IPv6 words: commit any pending group, then open the gap.
  always_comb begin
    fin_commit = (hcnt_q != '0);
    fin_err    = err_q;
    if (fin_commit) begin
      fin_err = fin_err || (gcnt_q >= 4'(NumGroups));
    end else begin
      fin_err = fin_err || (cph_q == CP_SINGLE) || (cph_q == CP_LEAD);
    end
    gcnt_f  = gcnt_q + 4'(fin_commit);
    cnt_bad = gap_q ? (gcnt_f > 4'(NumGroups - 1)) : (gcnt_f != 4'(NumGroups));
    shift   = gap_q ? (4'(NumGroups) - gcnt_f) : '0;
    for (int i = 0; i < NumGroups; i++) begin
      grp_f[i] = (fin_commit && (gcnt_q == 4'(i))) ? gval_q : grp_q[i];
      words[i] = '0;
    end
    slot = '0;
    for (int i = 0; i < NumGroups; i++) begin
      slot = (4'(i) < gpos_q) ? 4'(i) : 4'(i) + shift;
      if (4'(i) < gcnt_f) begin
        words[slot[2:0]] = grp_f[i];
      end
    end
  end

  always_comb begin
    status_d = ST_NOFAM;
    hi_d     = '0;
    lo_d     = '0;
    if (fam_cur == FAM_V4) begin
      if (err_q || (oct_cnt_q != 2'd3) || !dig_q) begin
        status_d = ST_BAD;
      end else begin
        status_d = ST_OK;
        lo_d     = {32'd0, octs_q[0], octs_q[1], octs_q[2], oct_val_q};
      end
    end else if (fam_cur == FAM_V6) begin
      if (fin_err || cnt_bad) begin
        status_d = ST_BAD;
      end else begin
        status_d = ST_OK;
        hi_d     = {words[0], words[1], words[2], words[3]};
        lo_d     = {words[4], words[5], words[6], words[7]};
      end
    end
  end

  always_comb begin
    fam_d       = fam_q;
    start_d     = start_q;
    err_d       = err_q;
    oct_val_d   = oct_val_q;
    dig_d       = dig_q;
    oct_cnt_d   = oct_cnt_q;
    oct_we      = 1'b0;
    grp_we      = 1'b0;
    gcnt_d      = gcnt_q;
    gpos_d      = gpos_q;
    gap_d       = gap_q;
    gval_d      = gval_q;
    hcnt_d      = hcnt_q;
    cph_d       = cph_q;
    out_valid_d = out_valid_q && !out_o.ready;

    if (in_fire) begin
      fam_d = fam_cur;
      if (is_term) begin
        out_valid_d = 1'b1;
        start_d     = 1'b1;
        err_d       = 1'b0;
        oct_val_d   = '0;
        dig_d       = 1'b0;
        oct_cnt_d   = '0;
        gcnt_d      = '0;
        gpos_d      = '0;
        gap_d       = 1'b0;
        gval_d      = '0;
        hcnt_d      = '0;
        cph_d       = CP_NONE;
      end else begin
        start_d = 1'b0;
        if (!err_q && (fam_cur == FAM_V4)) begin
          if (dec.ok) begin
            if (v4_sum > OctetMax) begin
              err_d = 1'b1;
            end else begin
              oct_val_d = v4_sum[7:0];
              dig_d     = 1'b1;
            end
          end else if (in_i.text_char == CH_DOT) begin
            if (!dig_q || (oct_cnt_q == 2'd3)) begin
              err_d = 1'b1;
            end else begin
              oct_we    = 1'b1;
              oct_cnt_d = oct_cnt_q + 2'd1;
              oct_val_d = '0;
              dig_d     = 1'b0;
            end
          end else begin
            err_d = 1'b1;
          end
        end else if (!err_q && (fam_cur == FAM_V6)) begin
          if (hex.ok) begin
            if ((cph_q == CP_LEAD) || (hcnt_q >= 3'(MaxHexDigits))) begin
              err_d = 1'b1;
            end else if ((hcnt_q == '0) && (gcnt_q >= 4'(NumGroups))) begin
              err_d = 1'b1;
            end else begin
              gval_d = {gval_q[11:0], hex.value};
              hcnt_d = hcnt_q + 3'd1;
              cph_d  = CP_NONE;
            end
          end else if (in_i.text_char == CH_COLON) begin
            priority if (hcnt_q != '0) begin
              if (gcnt_q >= 4'(NumGroups)) begin
                err_d = 1'b1;
              end else begin
                grp_we = 1'b1;
                gcnt_d = gcnt_q + 4'd1;
                gval_d = '0;
                hcnt_d = '0;
              end
              cph_d = CP_SINGLE;
            end else if ((cph_q == CP_SINGLE) || (cph_q == CP_LEAD)) begin
              if (gap_q) begin
                err_d = 1'b1;
              end else begin
                gap_d  = 1'b1;
                gpos_d = gcnt_q;
                cph_d  = CP_GAP;
              end
            end else if (cph_q == CP_NONE) begin
              cph_d = CP_LEAD;
            end else begin
              err_d = 1'b1;
            end
          end else begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fam_q       <= '0;
      start_q     <= 1'b1;
      err_q       <= 1'b0;
      oct_val_q   <= '0;
      dig_q       <= 1'b0;
      oct_cnt_q   <= '0;
      gcnt_q      <= '0;
      gpos_q      <= '0;
      gap_q       <= 1'b0;
      gval_q      <= '0;
      hcnt_q      <= '0;
      cph_q       <= CP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      fam_q       <= fam_d;
      start_q     <= start_d;
      err_q       <= err_d;
      oct_val_q   <= oct_val_d;
      dig_q       <= dig_d;
      oct_cnt_q   <= oct_cnt_d;
      gcnt_q      <= gcnt_d;
      gpos_q      <= gpos_d;
      gap_q       <= gap_d;
      gval_q      <= gval_d;
      hcnt_q      <= hcnt_d;
      cph_q       <= cph_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stored octets and groups are only read below their fill counts.
  always_ff @(posedge clk_i) begin
    if (oct_we) begin
      octs_q[oct_cnt_q] <= oct_val_q;
    end
    if (grp_we) begin
      grp_q[gcnt_q[2:0]] <= gval_q;
    end
    if (in_fire && is_term) begin
      status_q <= status_d;
      hi_q     <= hi_d;
      lo_q     <= lo_d;
    end
  end

  a_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !is_term |=> !out_valid_q)
    else $error("result raised by a non-terminating character");

  a_term_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_term |=> out_valid_q && start_q)
    else $error("terminator did not produce a result and restart");

  a_nofam_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != ST_OK) |-> (hi_q == '0) && (lo_q == '0))
    else $error("failed parse carries a non-zero address");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gcnt_q <= 4'(NumGroups)) && (hcnt_q <= 3'(MaxHexDigits)))
    else $error("group or digit count out of range");

  a_err_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_term && err_q && ((fam_cur == FAM_V4) || (fam_cur == FAM_V6))
    |=> status_q == ST_BAD)
    else $error("error seen but result not malformed");

endmodule

`default_nettype wire
